/* src/mie_pkg.sv */
// Package for the extended Euclidean modular inverse block.
// Holds the sequencer state type; no dependencies.
package mie_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINAL
  } state_t;

endpackage

/* src/modular_inverse_ext_euclid.sv */
// Modular inverse by extended Euclid with one shared divide step; depends on mie_pkg.
// Sequence per Euclid iteration: check, divide steps, update; then the result loads;
//   at most 45 iterations for 32-bit operands.
// One request at a time; the restoring divider takes one quotient bit a cycle;
//   in_ready returns in the cycle after the result loads, even while it waits to be read.
// Reset: synchronous active-low rst_n returns the sequencer to idle, output empty.
module modular_inverse_ext_euclid #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_inverse
);

  localparam int CNT_W = $clog2(WIDTH);

  mie_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] r0_r, r0_nxt;
  logic [WIDTH-1:0] r1_r, r1_nxt;
  logic [WIDTH:0]   c0_r, c0_nxt;
  logic             c0_neg_r, c0_neg_nxt;
  logic [WIDTH:0]   c1_r, c1_nxt;
  logic             c1_neg_r, c1_neg_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_inverse_r, out_inverse_nxt;

  logic [WIDTH-1:0] op_a, op_b;
  logic [WIDTH:0]   trial;
  logic             q_bit;
  logic [WIDTH-1:0] result_w;
  logic             accept;
  logic             load_out;
  logic             last_bit;

  // Operands brought to WIDTH bits
  assign op_a = WIDTH'({32'b0, in_operand_a});
  assign op_b = WIDTH'({32'b0, in_operand_b});

  assign accept   = in_valid && in_ready;
  assign last_bit = (cnt_r == CNT_W'(WIDTH - 1));

  // Shared divide step: shift in next dividend bit, trial subtract
  assign trial = {rem_r, dvd_r[WIDTH-1]} - {1'b0, r1_r};
  assign q_bit = ~trial[WIDTH];

  // Reduce a negative coefficient into 0..m-1
  assign result_w = (c0_neg_r && (c0_r != '0)) ? (m_r - c0_r[WIDTH-1:0]) : c0_r[WIDTH-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_CHECK: begin
        state_nxt = (r1_r == '0) ? mie_pkg::ST_FINAL : mie_pkg::ST_DIV;
      end
      mie_pkg::ST_DIV: begin
        if (last_bit) state_nxt = mie_pkg::ST_UPDATE;
      end
      mie_pkg::ST_UPDATE: begin
        state_nxt = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_FINAL: begin
        if (!out_valid_r || out_ready) state_nxt = mie_pkg::ST_IDLE;
      end
      default: state_nxt = mie_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      mie_pkg::ST_IDLE:  in_ready = 1'b1;
      mie_pkg::ST_FINAL: load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    m_nxt           = m_r;
    r0_nxt          = r0_r;
    r1_nxt          = r1_r;
    c0_nxt          = c0_r;
    c0_neg_nxt      = c0_neg_r;
    c1_nxt          = c1_r;
    c1_neg_nxt      = c1_neg_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    out_inverse_nxt = out_inverse_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    // Load request, larger operand becomes the modulus
    if (accept) begin
      if (op_a < op_b) begin
        m_nxt  = op_b;
        r0_nxt = op_b;
        r1_nxt = op_a;
      end else begin
        m_nxt  = op_a;
        r0_nxt = op_a;
        r1_nxt = op_b;
      end
      c0_nxt     = '0;
      c0_neg_nxt = 1'b0;
      c1_nxt     = (WIDTH+1)'(1);
      c1_neg_nxt = 1'b0;
    end

    case (state_r)
      mie_pkg::ST_CHECK: begin
        rem_nxt = '0;
        dvd_nxt = r0_r;
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      // One quotient bit a cycle; acc builds q * c1 MSB first
      mie_pkg::ST_DIV: begin
        rem_nxt = q_bit ? trial[WIDTH-1:0] : {rem_r[WIDTH-2:0], dvd_r[WIDTH-1]};
        dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
        acc_nxt = {acc_r[WIDTH-1:0], 1'b0} + (q_bit ? c1_r : '0);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      // Rotate remainders and coefficients; signs alternate
      mie_pkg::ST_UPDATE: begin
        r0_nxt     = r1_r;
        r1_nxt     = rem_r;
        c0_nxt     = c1_r;
        c0_neg_nxt = c1_neg_r;
        c1_nxt     = c0_r + acc_r;
        c1_neg_nxt = !c1_neg_r;
      end
      default: begin
      end
    endcase

    if (load_out) begin
      out_inverse_nxt = 32'(64'(result_w));
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r           <= m_nxt;
    r0_r          <= r0_nxt;
    r1_r          <= r1_nxt;
    c0_r          <= c0_nxt;
    c0_neg_r      <= c0_neg_nxt;
    c1_r          <= c1_nxt;
    c1_neg_r      <= c1_neg_nxt;
    rem_r         <= rem_nxt;
    dvd_r         <= dvd_nxt;
    acc_r         <= acc_nxt;
    cnt_r         <= cnt_nxt;
    out_inverse_r <= out_inverse_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;

  // Checks
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == mie_pkg::ST_CHECK)
    else $error("accepted request did not start the sequencer");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mie_pkg::ST_DIV |-> rem_r < r1_r)
    else $error("partial remainder not below divisor");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mie_pkg::ST_DIV && last_bit |=> state_r == mie_pkg::ST_UPDATE)
    else $error("divide pass did not end after WIDTH steps");

  a_coef_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mie_pkg::ST_FINAL |-> c0_r <= {1'b0, m_r})
    else $error("final coefficient exceeds modulus");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for modular_inverse_ext_euclid (extended Euclid inverse).
// Needs only the RTL: src/mie_pkg.sv and src/modular_inverse_ext_euclid.sv.
module tb;

  localparam int OP_W           = 32;
  localparam int RANDOM_COUNT   = 370;
  // Covers the worst request plus the longest stall and gap, taken ~10x over
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_DRAIN      = 100;

  typedef struct packed {
    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
    logic            drain_first;
  } request_t;

  typedef struct packed {
    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
    logic [OP_W-1:0] inverse;
  } inv_expect_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [OP_W-1:0] in_operand_a = '0;
  logic [OP_W-1:0] in_operand_b = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [OP_W-1:0] out_inverse;

  request_t    request_q[$];
  inv_expect_t inverse_q[$];
  request_t    next_req;
  inv_expect_t got_exp;

  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   out_stall = 0;
  int   quiet_left = 0;
  int   idle_cycles = 0;
  int   error_count = 0;
  int   results_checked = 0;
  int   directed_count = 0;
  int   drain_pauses = 0;

  modular_inverse_ext_euclid #(.WIDTH(OP_W)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_inverse (out_inverse)
  );

  always #4 clk = ~clk;

  // Extended Euclid on (larger, smaller); coefficient kept as magnitude plus sign
  function automatic logic [OP_W-1:0] calc_inverse(input logic [OP_W-1:0] op_a,
                                                    input logic [OP_W-1:0] op_b);
    logic [63:0] modulus, rem_prev, rem_cur, rem_next, quot;
    logic [63:0] coef_prev, coef_cur, coef_next;
    logic        neg_prev, neg_cur;
    logic [63:0] reduced;
    modulus  = (op_a < op_b) ? 64'(op_b) : 64'(op_a);
    rem_prev = modulus;
    rem_cur  = (op_a < op_b) ? 64'(op_a) : 64'(op_b);
    coef_prev = 64'd0;
    coef_cur  = 64'd1;
    neg_prev  = 1'b0;
    neg_cur   = 1'b0;
    while (rem_cur != 64'd0) begin
      quot      = rem_prev / rem_cur;
      rem_next  = rem_prev % rem_cur;
      // signs alternate, so the new magnitude is a sum
      coef_next = coef_prev + quot * coef_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_prev = coef_cur;
      neg_prev  = neg_cur;
      coef_cur  = coef_next;
      neg_cur   = ~neg_cur;
    end
    if (neg_prev && coef_prev != 64'd0) reduced = modulus - coef_prev;
    else reduced = coef_prev;
    return reduced[OP_W-1:0];
  endfunction

  // Random value with a random bit length, so small operands show up often
  function automatic logic [OP_W-1:0] rand_bits();
    int len;
    len = $urandom_range(1, OP_W);
    return $urandom & ({OP_W{1'b1}} >> (OP_W - len));
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(input string what, input logic [OP_W-1:0] op_a,
                                 input logic [OP_W-1:0] op_b,
                                 input logic [OP_W-1:0] exp_v,
                                 input logic [OP_W-1:0] got_v);
    $display("[%0t] MISMATCH %s: a=%h b=%h expected %h got %h",
             $realtime, what, op_a, op_b, exp_v, got_v);
    error_count++;
  endtask

  task automatic add_request(input logic [OP_W-1:0] op_a, input logic [OP_W-1:0] op_b,
                             input logic drain_first);
    request_q.push_back('{op_a: op_a, op_b: op_b, drain_first: drain_first});
  endtask

  // Request driver: changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until the request is taken
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (request_q.size() != 0 && request_q[0].drain_first &&
                 inverse_q.size() != 0) begin
      // wait for every outstanding result before this request
      in_valid <= 1'b0;
    end else if (request_q.size() != 0) begin
      next_req = request_q.pop_front();
      if (next_req.drain_first) drain_pauses++;
      in_valid     <= 1'b1;
      in_operand_a <= next_req.op_a;
      in_operand_b <= next_req.op_b;
      if (quiet_left != 0) begin
        quiet_left <= quiet_left - 1;
        send_gap   <= 0;
      end else if ($urandom_range(0, 29) == 0) begin
        quiet_left <= $urandom_range(20, 40);
        send_gap   <= 0;
      end else begin
        send_gap <= pick_gap();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (quiet_left == 0 && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_stall <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on request accept, check on result accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("result with no request pending", '0, '0, '0, out_inverse);
        end else begin
          got_exp = inverse_q.pop_front();
          results_checked++;
          if (out_inverse !== got_exp.inverse)
            report_mismatch("inverse", got_exp.op_a, got_exp.op_b, got_exp.inverse,
                            out_inverse);
        end
      end
      if (in_valid && in_ready)
        inverse_q.push_back('{op_a: in_operand_a, op_b: in_operand_b,
                              inverse: calc_inverse(in_operand_a, in_operand_b)});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and run control
  initial begin
    logic [OP_W-1:0] ra, rb, fib_lo, fib_hi, fib_sum, factor;
    int kind, steps;

    // Directed: zero operands, equal operands, extremes, swap, gcd not one
    add_request(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_request(32'h0000_0000, 32'h0000_0005, 1'b0);
    add_request(32'h0000_0005, 32'h0000_0000, 1'b0);
    add_request(32'h0000_0001, 32'h0000_0001, 1'b0);
    add_request(32'h0000_0007, 32'h0000_0007, 1'b0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    add_request(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    add_request(32'd17, 32'd3, 1'b0);
    add_request(32'd3, 32'd17, 1'b0);
    add_request(32'd3120, 32'd17, 1'b0);
    add_request(32'd12, 32'd18, 1'b0);
    add_request(32'd100, 32'd75, 1'b0);
    add_request(32'd2971215073, 32'd1836311903, 1'b0);  // longest Euclid chain
    add_request(32'h8000_0000, 32'h0000_0003, 1'b0);
    add_request(32'hFFFF_FFFB, 32'h0000_0002, 1'b0);
    add_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    directed_count = request_q.size();

    // Random mix; the first one waits for the directed results to drain
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        ra = $urandom;
        rb = $urandom;
      end else if (kind < 50) begin
        ra = rand_bits();
        rb = rand_bits();
      end else if (kind < 62) begin
        // power-of-two modulus, odd value
        steps = $urandom_range(1, OP_W - 1);
        ra = 32'd1 << steps;
        rb = ($urandom & (ra - 32'd1)) | 32'd1;
      end else if (kind < 72) begin
        // common factor, so gcd is not one
        factor = $urandom_range(2, 1000);
        ra = ($urandom & 32'h003F_FFFF) * factor;
        rb = ($urandom & 32'h003F_FFFF) * factor;
      end else if (kind < 78) begin
        ra = rand_bits();
        rb = ra;
      end else if (kind < 84) begin
        ra = $urandom_range(0, 1);
        rb = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          rb = ra;
          ra = $urandom;
        end
      end else if (kind < 90) begin
        // consecutive Fibonacci numbers give the longest chains
        fib_lo = 32'd1;
        fib_hi = 32'd1;
        steps  = $urandom_range(1, 45);
        for (int s = 0; s < steps; s++) begin
          fib_sum = fib_lo + fib_hi;
          fib_lo  = fib_hi;
          fib_hi  = fib_sum;
        end
        ra = fib_hi;
        rb = fib_lo;
        if ($urandom_range(0, 1) == 1) begin
          ra = fib_lo;
          rb = fib_hi;
        end
      end else begin
        // smaller value first, forces the swap
        ra = $urandom;
        rb = $urandom;
        if (ra > rb) begin
          fib_sum = ra;
          ra = rb;
          rb = fib_sum;
        end
      end
      add_request(ra, rb, (i == 0) || ($urandom_range(0, 29) == 0));
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((request_q.size() != 0 || in_valid || inverse_q.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
               $realtime, WATCHDOG_LIMIT, inverse_q.size());
      $display("Testbench completed WITH ERRORS");
    end else begin
      // catch any stray result after the last one
      repeat (END_DRAIN) @(posedge clk);
      $display("Checked %0d inverses: %0d directed and %0d random requests,",
               results_checked, directed_count, RANDOM_COUNT);
      $display("including zero, equal, extreme, swapped and non-coprime operands; %0d drains",
               drain_pauses);
      if (error_count == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end

endmodule
